FILE: rtl/rvdec_pkg.sv
// Shared types and encodings for the RV64I instruction decoder.
// Pure declarations; no dependencies.
`default_nettype none

package rvdec_pkg;

   localparam int unsigned INSTR_W = 32;
   localparam int unsigned REG_W   = 5;
   localparam int unsigned IMM_W   = 32;
   localparam int unsigned OPER_W  = 6;

   // major opcodes, bits 6..0
   localparam logic [6:0] OPC_LUI    = 7'b0110111;
   localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;
   localparam logic [6:0] OPC_JALR   = 7'b1100111;
   localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_OP     = 7'b0110011;
   localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
   localparam logic [6:0] OPC_OPIMMW = 7'b0011011;
   localparam logic [6:0] OPC_OPW    = 7'b0111011;

   // funct3, ALU group
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   // funct3, loads and stores
   localparam logic [2:0] F3_LB  = 3'd0;
   localparam logic [2:0] F3_LH  = 3'd1;
   localparam logic [2:0] F3_LW  = 3'd2;
   localparam logic [2:0] F3_LD  = 3'd3;
   localparam logic [2:0] F3_LBU = 3'd4;
   localparam logic [2:0] F3_LHU = 3'd5;
   localparam logic [2:0] F3_LWU = 3'd6;

   // funct3, branches
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   typedef enum logic [OPER_W-1:0] {
      OP_LUI, OP_AUIPC, OP_JAL, OP_JALR,
      OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI,
      OP_SLLI, OP_SRLI, OP_SRAI,
      OP_LB, OP_LH, OP_LW, OP_LD, OP_LBU, OP_LHU, OP_LWU,
      OP_SB, OP_SH, OP_SW, OP_SD,
      OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
      OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA,
      OP_OR, OP_AND, OP_ECALL,
      OP_ADDIW, OP_SLLIW, OP_SRLIW, OP_SRAIW,
      OP_ADDW, OP_SUBW, OP_SLLW, OP_SRLW, OP_SRAW
   } op_type;

   localparam op_type OP_LAST = OP_SRAW;

   typedef struct packed {
      op_type                  operation;
      logic                    illegal;
      logic [REG_W-1:0]        dest_reg;
      logic [REG_W-1:0]        src1_reg;
      logic [REG_W-1:0]        src2_reg;
      logic signed [IMM_W-1:0] immediate;
   } dec_type;

endpackage

`default_nettype wire

FILE: rtl/rvdec_core.sv
// Combinational decode of one RV64I instruction word into a dec_type.
// Depends on rvdec_pkg.
`default_nettype none

module rvdec_core (
   input  wire logic [rvdec_pkg::INSTR_W-1:0] instr_word,
   output rvdec_pkg::dec_type                 dec
);

   logic [6:0] opc;
   logic [2:0] f3;
   logic       f7_zero;
   logic       bit30;
   logic       bad;
   rvdec_pkg::op_type op;
   logic [rvdec_pkg::IMM_W-1:0] imm;
   logic [rvdec_pkg::IMM_W-1:0] imm_i, imm_s, imm_b, imm_u, imm_j;

   assign opc     = instr_word[6:0];
   assign f3      = instr_word[14:12];
   assign f7_zero = (instr_word[31:25] == 7'd0);
   assign bit30   = instr_word[30];

   assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
   assign imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
   assign imm_b = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                   instr_word[30:25], instr_word[11:8], 1'b0};
   assign imm_u = {instr_word[31:12], 12'd0};
   assign imm_j = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                   instr_word[20], instr_word[30:21], 1'b0};

   always_comb begin
      op  = rvdec_pkg::OP_LUI;
      imm = '0;
      bad = 1'b0;
      case (opc)
         rvdec_pkg::OPC_LUI: begin
            op  = rvdec_pkg::OP_LUI;
            imm = imm_u;
         end
         rvdec_pkg::OPC_AUIPC: begin
            op  = rvdec_pkg::OP_AUIPC;
            imm = imm_u;
         end
         rvdec_pkg::OPC_JAL: begin
            op  = rvdec_pkg::OP_JAL;
            imm = imm_j;
         end
         rvdec_pkg::OPC_JALR: begin
            op  = rvdec_pkg::OP_JALR;
            imm = imm_i;
         end
         rvdec_pkg::OPC_OPIMM: begin
            imm = imm_i;
            case (f3)
               rvdec_pkg::F3_ADD:  op = rvdec_pkg::OP_ADDI;
               rvdec_pkg::F3_SLL:  op = rvdec_pkg::OP_SLLI;
               rvdec_pkg::F3_SLT:  op = rvdec_pkg::OP_SLTI;
               rvdec_pkg::F3_SLTU: op = rvdec_pkg::OP_SLTIU;
               rvdec_pkg::F3_XOR:  op = rvdec_pkg::OP_XORI;
               rvdec_pkg::F3_SR:   op = bit30 ? rvdec_pkg::OP_SRAI : rvdec_pkg::OP_SRLI;
               rvdec_pkg::F3_OR:   op = rvdec_pkg::OP_ORI;
               default:            op = rvdec_pkg::OP_ANDI;
            endcase
         end
         rvdec_pkg::OPC_LOAD: begin
            imm = imm_i;
            case (f3)
               rvdec_pkg::F3_LB:  op = rvdec_pkg::OP_LB;
               rvdec_pkg::F3_LH:  op = rvdec_pkg::OP_LH;
               rvdec_pkg::F3_LW:  op = rvdec_pkg::OP_LW;
               rvdec_pkg::F3_LD:  op = rvdec_pkg::OP_LD;
               rvdec_pkg::F3_LBU: op = rvdec_pkg::OP_LBU;
               rvdec_pkg::F3_LHU: op = rvdec_pkg::OP_LHU;
               rvdec_pkg::F3_LWU: op = rvdec_pkg::OP_LWU;
               default:           bad = 1'b1;
            endcase
         end
         rvdec_pkg::OPC_STORE: begin
            imm = imm_s;
            case (f3)
               rvdec_pkg::F3_LB: op = rvdec_pkg::OP_SB;
               rvdec_pkg::F3_LH: op = rvdec_pkg::OP_SH;
               rvdec_pkg::F3_LW: op = rvdec_pkg::OP_SW;
               rvdec_pkg::F3_LD: op = rvdec_pkg::OP_SD;
               default:          bad = 1'b1;
            endcase
         end
         rvdec_pkg::OPC_BRANCH: begin
            imm = imm_b;
            case (f3)
               rvdec_pkg::F3_BEQ:  op = rvdec_pkg::OP_BEQ;
               rvdec_pkg::F3_BNE:  op = rvdec_pkg::OP_BNE;
               rvdec_pkg::F3_BLT:  op = rvdec_pkg::OP_BLT;
               rvdec_pkg::F3_BGE:  op = rvdec_pkg::OP_BGE;
               rvdec_pkg::F3_BLTU: op = rvdec_pkg::OP_BLTU;
               rvdec_pkg::F3_BGEU: op = rvdec_pkg::OP_BGEU;
               default:            bad = 1'b1;
            endcase
         end
         rvdec_pkg::OPC_OP: begin
            case (f3)
               rvdec_pkg::F3_ADD:  op = f7_zero ? rvdec_pkg::OP_ADD : rvdec_pkg::OP_SUB;
               rvdec_pkg::F3_SLL:  op = rvdec_pkg::OP_SLL;
               rvdec_pkg::F3_SLT:  op = rvdec_pkg::OP_SLT;
               rvdec_pkg::F3_SLTU: op = rvdec_pkg::OP_SLTU;
               rvdec_pkg::F3_XOR:  op = rvdec_pkg::OP_XOR;
               rvdec_pkg::F3_SR:   op = f7_zero ? rvdec_pkg::OP_SRL : rvdec_pkg::OP_SRA;
               rvdec_pkg::F3_OR:   op = rvdec_pkg::OP_OR;
               default:            op = rvdec_pkg::OP_AND;
            endcase
         end
         rvdec_pkg::OPC_SYSTEM: begin
            // every funct3 decodes as ecall
            op  = rvdec_pkg::OP_ECALL;
            imm = imm_i;
         end
         rvdec_pkg::OPC_OPIMMW: begin
            imm = imm_i;
            case (f3)
               rvdec_pkg::F3_ADD: op = rvdec_pkg::OP_ADDIW;
               rvdec_pkg::F3_SLL: op = rvdec_pkg::OP_SLLIW;
               rvdec_pkg::F3_SR:  op = bit30 ? rvdec_pkg::OP_SRAIW : rvdec_pkg::OP_SRLIW;
               default:           bad = 1'b1;
            endcase
         end
         rvdec_pkg::OPC_OPW: begin
            case (f3)
               rvdec_pkg::F3_ADD: op = f7_zero ? rvdec_pkg::OP_ADDW : rvdec_pkg::OP_SUBW;
               rvdec_pkg::F3_SLL: op = rvdec_pkg::OP_SLLW;
               rvdec_pkg::F3_SR:  op = f7_zero ? rvdec_pkg::OP_SRLW : rvdec_pkg::OP_SRAW;
               default:           bad = 1'b1;
            endcase
         end
         default: bad = 1'b1;
      endcase
   end

   // illegal words report operation 0 and a zero immediate
   always_comb begin
      dec.illegal   = bad;
      dec.operation = bad ? rvdec_pkg::OP_LUI : op;
      dec.immediate = bad ? '0 : $signed(imm);
      dec.dest_reg  = instr_word[11:7];
      dec.src1_reg  = instr_word[19:15];
      dec.src2_reg  = instr_word[24:20];
   end

endmodule

`default_nettype wire

FILE: rtl/rv64i_instruction_decoder_top.sv
// Top level of the RV64I instruction decoder: input register, decode, result register.
// Depends on rvdec_pkg and rvdec_core.
//
// Usage:
//  - req channel: one 32-bit instruction word per transaction on req_tdata.
//  - rsp channel: one decoded result per transaction. rsp_tdata carries operation,
//    rd, rs1, rs2 and the sign-extended immediate; rsp_tuser carries the illegal flag.
//  - Path: a request word passes through the input register, then the decode, then the
//    result register, which drives rsp_tvalid and the response payload.
//  - Throughput: one transaction per cycle while rsp_tready stays high, set by the single
//    decode pass between the two registers; requests and responses may flow back to back.
//  - Stall: when rsp_tready is low a full result register holds, the input register
//    keeps accepting until it too is full, then req_tready drops. Nothing is lost
//    or duplicated; each stage advances when it is empty or its consumer takes data.
//  - Reset (synchronous, active high): both stages are emptied; payload registers
//    are not cleared.
//  - Illegal words: operation and immediate read as zero, register fields pass raw.
`default_nettype none

module rv64i_instruction_decoder_top (
   input  wire  logic        clock,
   input  wire  logic        reset,
   // request channel
   input  wire  logic        req_tvalid,
   output logic              req_tready,
   input  wire  logic [31:0] req_tdata,   // [31:0] instruction_word
   // response channel
   output logic              rsp_tvalid,
   input  wire  logic        rsp_tready,
   output logic [55:0]       rsp_tdata,   // [5:0] operation, [10:6] dest_reg,
                                          // [15:11] src1_reg, [20:16] src2_reg,
                                          // [52:21] immediate, [55:53] zero
   output logic              rsp_tuser    // [0] illegal
);

   // stage 1: instruction register
   logic                            s1_valid_ff, s1_valid_in;
   logic [rvdec_pkg::INSTR_W-1:0]   s1_word_ff, s1_word_in;
   logic                            s1_ready;

   // stage 2: result register
   logic                            rsp_valid_ff, rsp_valid_in;
   rvdec_pkg::dec_type              rsp_dec_ff, rsp_dec_in;
   rvdec_pkg::dec_type              dec;
   logic                            rsp_advance;

   rvdec_core u_core (
      .instr_word (s1_word_ff),
      .dec        (dec)
   );

   assign rsp_advance = !rsp_valid_ff || rsp_tready;
   assign s1_ready    = !s1_valid_ff || rsp_advance;
   assign req_tready  = s1_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_word_in  = s1_word_ff;
      if (s1_ready) begin
         s1_valid_in = req_tvalid;
         if (req_tvalid) begin
            s1_word_in = req_tdata;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_dec_in   = rsp_dec_ff;
      if (rsp_advance) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            rsp_dec_in = dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_word_ff <= s1_word_in;
      rsp_dec_ff <= rsp_dec_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_dec_ff.illegal;
   assign rsp_tdata  = {3'd0,
                        rsp_dec_ff.immediate,
                        rsp_dec_ff.src2_reg,
                        rsp_dec_ff.src1_reg,
                        rsp_dec_ff.dest_reg,
                        rsp_dec_ff.operation};

   // illegal results carry operation 0 and a zero immediate
   a_illegal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_dec_ff.illegal |->
         rsp_dec_ff.operation == rvdec_pkg::OP_LUI && rsp_dec_ff.immediate == '0)
      else $error("illegal result with nonzero operation or immediate");

   // every valid result stays within the operation range
   a_op_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_dec_ff.operation <= rvdec_pkg::OP_LAST)
      else $error("operation out of range");

   // a staged instruction is held while the result register is blocked
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !rsp_advance |=> s1_valid_ff && $stable(s1_word_ff))
      else $error("staged instruction lost under stall");

   // an accepted request always lands in stage 1
   a_s1_load: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid_ff && s1_word_ff == $past(req_tdata))
      else $error("accepted request not captured");

   // a staged instruction moves into the result register when it has room
   a_s2_load: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_advance |=> rsp_valid_ff)
      else $error("decoded result not registered");

endmodule

`default_nettype wire
